// File: hw/rtl/dsnp_pkg.sv
// Shared types and constants for the decimal scientific number parser.
// Used by the channel interfaces and by every parser module.
package dsnp_pkg;

  localparam int MAX_LINE_DEFAULT = 1024;

  localparam int CH_W   = 8;
  localparam int SIG_W  = 64;
  localparam int FRAC_W = 10;
  localparam int EXP_W  = 16;
  localparam int DIG_W  = 4;

  localparam logic [FRAC_W-1:0] FRAC_MAX = '1;

  localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CH_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CH_W-1:0] CH_POINT = 8'h2E;
  localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CH_W-1:0] CH_UP_E  = 8'h45;
  localparam logic [CH_W-1:0] CH_LO_E  = 8'h65;

  typedef enum logic [2:0] {
    PH_SPACE = 3'd0,
    PH_INT   = 3'd1,
    PH_FRAC  = 3'd2,
    PH_ESIGN = 3'd3,
    PH_EDIG  = 3'd4,
    PH_DONE  = 3'd5
  } phase_t;

  typedef struct packed {
    logic [CH_W-1:0] ch;
    logic            line_end;
  } char_word_t;

  typedef struct packed {
    logic              is_negative;
    logic [SIG_W-1:0]  significand;
    logic [FRAC_W-1:0] fraction_digits;
    logic              exponent_negative;
    logic [EXP_W-1:0]  exponent_value;
    logic              saturated;
  } result_t;

  typedef struct packed {
    logic add_sig;
    logic add_frac;
    logic add_exp;
    logic set_minus;
    logic set_exp_minus;
  } parse_act_t;

endpackage

// File: hw/rtl/dsnp_char_if.sv
// Character channel: valid/ready handshake carrying one text byte per word.
// Depends on dsnp_pkg for field widths.
interface dsnp_char_if;
  logic                      valid;
  logic                      ready;
  logic [dsnp_pkg::CH_W-1:0] ch;
  logic                      line_end;

  modport source(output valid, ch, line_end, input ready);
  modport sink(input valid, ch, line_end, output ready);
endinterface

// File: hw/rtl/dsnp_num_if.sv
// Result channel: valid/ready handshake carrying one parsed number per word.
// Depends on dsnp_pkg for field widths.
interface dsnp_num_if;
  logic                        valid;
  logic                        ready;
  logic                        is_negative;
  logic [dsnp_pkg::SIG_W-1:0]  significand;
  logic [dsnp_pkg::FRAC_W-1:0] fraction_digits;
  logic                        exponent_negative;
  logic [dsnp_pkg::EXP_W-1:0]  exponent_value;
  logic                        saturated;

  modport source(output valid, is_negative, significand, fraction_digits,
                 exponent_negative, exponent_value, saturated, input ready);
  modport sink(input valid, is_negative, significand, fraction_digits,
               exponent_negative, exponent_value, saturated, output ready);
endinterface

// File: hw/rtl/decimal_scientific_number_parser_unit.sv
// Decimal scientific number parser, one character word per cycle unless a line end waits on output.
// A line's last character passes the input register, then its result enters the result register.
// Throughput: 1 character per cycle unless output stalls; multiply-by-ten is combinational.
// Reset (rst, synchronous): clears the parser state and empties both registers.
// Depends on dsnp_pkg, dsnp_char_if, dsnp_num_if, dsnp_in_reg, dsnp_parse_core, dsnp_out_reg.
module decimal_scientific_number_parser_unit #(
  parameter int MAX_LINE = dsnp_pkg::MAX_LINE_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  dsnp_char_if.sink  char_in,
  dsnp_num_if.source num_out
);

  logic                 word_valid;
  dsnp_pkg::char_word_t word;
  logic                 consume;
  logic                 emit;
  logic                 out_free;
  dsnp_pkg::result_t    res;

  dsnp_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .char_in    (char_in),
    .consume    (consume),
    .word_valid (word_valid),
    .word       (word)
  );

  dsnp_parse_core #(
    .MAX_LINE (MAX_LINE)
  ) u_parse_core (
    .clk        (clk),
    .rst        (rst),
    .word_valid (word_valid),
    .word       (word),
    .out_free   (out_free),
    .consume    (consume),
    .emit       (emit),
    .res        (res)
  );

  dsnp_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .emit     (emit),
    .res      (res),
    .out_free (out_free),
    .num_out  (num_out)
  );

endmodule

// File: hw/rtl/dsnp_in_reg.sv
// Input register: captures one character word from the input channel.
// Depends on dsnp_pkg and dsnp_char_if.
module dsnp_in_reg (
  input  logic                 clk,
  input  logic                 rst,
  dsnp_char_if.sink            char_in,
  input  logic                 consume,
  output logic                 word_valid,
  output dsnp_pkg::char_word_t word
);

  logic load;

  assign char_in.ready = !word_valid || consume;
  assign load          = char_in.valid && char_in.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else begin
      word_valid <= load || (word_valid && !consume);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word.ch       <= char_in.ch;
      word.line_end <= char_in.line_end;
    end
  end

endmodule

// File: hw/rtl/dsnp_parse_core.sv
// Parser state and per-character update: phase, sign, significand,
// fraction count, exponent and clip flag. Depends on dsnp_pkg.
module dsnp_parse_core #(
  parameter int MAX_LINE = dsnp_pkg::MAX_LINE_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 word_valid,
  input  dsnp_pkg::char_word_t word,
  input  logic                 out_free,
  output logic                 consume,
  output logic                 emit,
  output dsnp_pkg::result_t    res
);

  localparam int CNT_W = $clog2(MAX_LINE);
  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_LINE - 1);

  dsnp_pkg::phase_t                  phase, phase_next;
  logic                              minus_seen, minus_seen_next;
  logic [dsnp_pkg::SIG_W-1:0]        digit_accum, digit_accum_next;
  logic [dsnp_pkg::FRAC_W-1:0]       frac_count, frac_count_next;
  logic                              exp_minus, exp_minus_next;
  logic [dsnp_pkg::EXP_W-1:0]        exp_accum, exp_accum_next;
  logic                              clip_flag, clip_flag_next;
  logic [CNT_W-1:0]                  char_count;

  logic                              parse;
  logic                              is_dig, is_exp_ch, is_space;
  logic [dsnp_pkg::DIG_W-1:0]        dig;
  logic [dsnp_pkg::SIG_W+3:0]        sig_prod;
  logic [dsnp_pkg::EXP_W+3:0]        exp_prod;
  logic                              sig_ovf, exp_ovf, frac_full;
  dsnp_pkg::parse_act_t              act;

  assign consume = word_valid && (!word.line_end || out_free);
  assign emit    = consume && word.line_end;
  assign parse   = consume && (char_count < CNT_LIMIT);

  assign is_dig    = (word.ch >= dsnp_pkg::CH_ZERO) && (word.ch <= dsnp_pkg::CH_NINE);
  assign is_exp_ch = (word.ch == dsnp_pkg::CH_UP_E) || (word.ch == dsnp_pkg::CH_LO_E);
  assign is_space  = word.ch inside {dsnp_pkg::CH_SPACE, [dsnp_pkg::CH_TAB:dsnp_pkg::CH_CR]};
  assign dig       = dsnp_pkg::DIG_W'(word.ch - dsnp_pkg::CH_ZERO);

  assign sig_prod = ({4'b0, digit_accum} << 3) + ({4'b0, digit_accum} << 1)
                  + (dsnp_pkg::SIG_W+4)'(dig);
  assign sig_ovf  = |sig_prod[dsnp_pkg::SIG_W+3:dsnp_pkg::SIG_W];
  assign exp_prod = ({4'b0, exp_accum} << 3) + ({4'b0, exp_accum} << 1)
                  + (dsnp_pkg::EXP_W+4)'(dig);
  assign exp_ovf  = |exp_prod[dsnp_pkg::EXP_W+3:dsnp_pkg::EXP_W];
  assign frac_full = (frac_count == dsnp_pkg::FRAC_MAX);

  always_comb begin
    phase_next = phase;
    case (phase)
      dsnp_pkg::PH_SPACE: begin
        if (is_space) phase_next = dsnp_pkg::PH_SPACE;
        else if (word.ch == dsnp_pkg::CH_MINUS || word.ch == dsnp_pkg::CH_PLUS || is_dig)
          phase_next = dsnp_pkg::PH_INT;
        else if (word.ch == dsnp_pkg::CH_POINT) phase_next = dsnp_pkg::PH_FRAC;
        else if (is_exp_ch) phase_next = dsnp_pkg::PH_ESIGN;
        else phase_next = dsnp_pkg::PH_DONE;
      end
      dsnp_pkg::PH_INT: begin
        if (is_dig) phase_next = dsnp_pkg::PH_INT;
        else if (word.ch == dsnp_pkg::CH_POINT) phase_next = dsnp_pkg::PH_FRAC;
        else if (is_exp_ch) phase_next = dsnp_pkg::PH_ESIGN;
        else phase_next = dsnp_pkg::PH_DONE;
      end
      dsnp_pkg::PH_FRAC: begin
        if (is_dig) phase_next = dsnp_pkg::PH_FRAC;
        else if (is_exp_ch) phase_next = dsnp_pkg::PH_ESIGN;
        else phase_next = dsnp_pkg::PH_DONE;
      end
      dsnp_pkg::PH_ESIGN: begin
        if (word.ch == dsnp_pkg::CH_MINUS || word.ch == dsnp_pkg::CH_PLUS || is_dig)
          phase_next = dsnp_pkg::PH_EDIG;
        else phase_next = dsnp_pkg::PH_DONE;
      end
      dsnp_pkg::PH_EDIG: begin
        if (is_dig) phase_next = dsnp_pkg::PH_EDIG;
        else phase_next = dsnp_pkg::PH_DONE;
      end
      default: phase_next = dsnp_pkg::PH_DONE;
    endcase
  end

  always_comb begin
    act = '0;
    case (phase)
      dsnp_pkg::PH_SPACE: begin
        act.set_minus = (word.ch == dsnp_pkg::CH_MINUS);
        act.add_sig   = is_dig;
      end
      dsnp_pkg::PH_INT: begin
        act.add_sig = is_dig;
      end
      dsnp_pkg::PH_FRAC: begin
        act.add_sig  = is_dig;
        act.add_frac = is_dig;
      end
      dsnp_pkg::PH_ESIGN: begin
        act.set_exp_minus = (word.ch == dsnp_pkg::CH_MINUS);
        act.add_exp       = is_dig;
      end
      dsnp_pkg::PH_EDIG: begin
        act.add_exp = is_dig;
      end
      default: act = '0;
    endcase
  end

  always_comb begin
    minus_seen_next  = minus_seen;
    digit_accum_next = digit_accum;
    frac_count_next  = frac_count;
    exp_minus_next   = exp_minus;
    exp_accum_next   = exp_accum;
    clip_flag_next   = clip_flag;
    if (parse) begin
      if (act.set_minus) minus_seen_next = 1'b1;
      if (act.set_exp_minus) exp_minus_next = 1'b1;
      if (act.add_sig) begin
        if (sig_ovf) begin
          digit_accum_next = '1;
          clip_flag_next   = 1'b1;
        end else begin
          digit_accum_next = sig_prod[dsnp_pkg::SIG_W-1:0];
        end
      end
      if (act.add_frac) begin
        if (frac_full) clip_flag_next = 1'b1;
        else frac_count_next = frac_count + 1'b1;
      end
      if (act.add_exp) begin
        if (exp_ovf) begin
          exp_accum_next = '1;
          clip_flag_next = 1'b1;
        end else begin
          exp_accum_next = exp_prod[dsnp_pkg::EXP_W-1:0];
        end
      end
    end
  end

  always_comb begin
    res.is_negative       = minus_seen_next;
    res.significand       = digit_accum_next;
    res.fraction_digits   = frac_count_next;
    res.exponent_negative = exp_minus_next;
    res.exponent_value    = exp_accum_next;
    res.saturated         = clip_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst || emit) begin
      phase       <= dsnp_pkg::PH_SPACE;
      minus_seen  <= 1'b0;
      digit_accum <= '0;
      frac_count  <= '0;
      exp_minus   <= 1'b0;
      exp_accum   <= '0;
      clip_flag   <= 1'b0;
      char_count  <= '0;
    end else if (parse) begin
      phase       <= phase_next;
      minus_seen  <= minus_seen_next;
      digit_accum <= digit_accum_next;
      frac_count  <= frac_count_next;
      exp_minus   <= exp_minus_next;
      exp_accum   <= exp_accum_next;
      clip_flag   <= clip_flag_next;
      char_count  <= char_count + 1'b1;
    end
  end

endmodule

// File: hw/rtl/dsnp_out_reg.sv
// Result register: holds one parsed number until the output channel takes it.
// Depends on dsnp_pkg and dsnp_num_if.
module dsnp_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              emit,
  input  dsnp_pkg::result_t res,
  output logic              out_free,
  dsnp_num_if.source        num_out
);

  logic              out_valid;
  dsnp_pkg::result_t held;

  assign out_free      = !out_valid || num_out.ready;
  assign num_out.valid = out_valid;

  assign num_out.is_negative       = held.is_negative;
  assign num_out.significand       = held.significand;
  assign num_out.fraction_digits   = held.fraction_digits;
  assign num_out.exponent_negative = held.exponent_negative;
  assign num_out.exponent_value    = held.exponent_value;
  assign num_out.saturated         = held.saturated;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= emit || (out_valid && !num_out.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      held <= res;
    end
  end

endmodule

// File: tb/tb_top.sv
// Self-checking bench for decimal_scientific_number_parser_unit: feeds text lines one byte
// per word and checks every parsed number against an in-bench scanner of the same grammar.
// Depends on dsnp_pkg, dsnp_char_if, dsnp_num_if and the parser RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINE_LIMIT = dsnp_pkg::MAX_LINE_DEFAULT;
  localparam int QUIET_LIMIT = 2000;
  localparam int TARGET_CHARS = 950;
  localparam logic [dsnp_pkg::EXP_W-1:0] EXP_TOP = '1;
  localparam logic [dsnp_pkg::SIG_W-1:0] SIG_TOP = '1;

  logic clk;
  logic rst;

  dsnp_char_if char_bus ();
  dsnp_num_if  num_bus ();

  decimal_scientific_number_parser_unit u_dut (
    .clk     (clk),
    .rst     (rst),
    .char_in (char_bus),
    .num_out (num_bus)
  );

  dsnp_pkg::char_word_t char_feed[$];
  logic [7:0]           line_buf[$];
  dsnp_pkg::result_t    expected_numbers[$];

  int fed_chars;
  int sent_count = 0;
  int quiet_cycles = 0;
  int fail_count = 0;
  int numbers_checked = 0;
  int clipped_numbers = 0;
  int line_count;

  // scanner state
  dsnp_pkg::phase_t            scan_phase;
  logic                        scan_minus;
  logic [dsnp_pkg::SIG_W-1:0]  scan_sig;
  logic [dsnp_pkg::FRAC_W-1:0] scan_frac;
  logic                        scan_exp_minus;
  logic [dsnp_pkg::EXP_W-1:0]  scan_exp;
  logic                        scan_clip;
  int                          scan_chars;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic calm_window();
    return sent_count >= 350 && sent_count < 550;
  endfunction

  task automatic clear_scan();
    scan_phase     = dsnp_pkg::PH_SPACE;
    scan_minus     = 1'b0;
    scan_sig       = '0;
    scan_frac      = '0;
    scan_exp_minus = 1'b0;
    scan_exp       = '0;
    scan_clip      = 1'b0;
    scan_chars     = 0;
  endtask

  task automatic add_sig_digit(input logic [7:0] c);
    logic [dsnp_pkg::SIG_W-1:0] d;
    logic [dsnp_pkg::SIG_W-1:0] lim;
    d   = dsnp_pkg::SIG_W'(c - dsnp_pkg::CH_ZERO);
    lim = (SIG_TOP - d) / 64'd10;
    if (scan_sig > lim) begin
      scan_sig  = SIG_TOP;
      scan_clip = 1'b1;
    end else begin
      scan_sig = scan_sig * 64'd10 + d;
    end
  endtask

  task automatic add_exp_digit(input logic [7:0] c);
    logic [31:0] v;
    v = 32'(scan_exp) * 32'd10 + 32'(c - dsnp_pkg::CH_ZERO);
    if (v > 32'(EXP_TOP)) begin
      scan_exp  = EXP_TOP;
      scan_clip = 1'b1;
    end else begin
      scan_exp = dsnp_pkg::EXP_W'(v);
    end
  endtask

  task automatic scan_char(input logic [7:0] c);
    logic dig;
    logic expch;
    dig   = c >= dsnp_pkg::CH_ZERO && c <= dsnp_pkg::CH_NINE;
    expch = c == dsnp_pkg::CH_UP_E || c == dsnp_pkg::CH_LO_E;
    case (scan_phase)
      dsnp_pkg::PH_SPACE: begin
        if (c == dsnp_pkg::CH_SPACE || (c >= dsnp_pkg::CH_TAB && c <= dsnp_pkg::CH_CR)) begin
        end else if (c == dsnp_pkg::CH_MINUS) begin
          scan_minus = 1'b1;
          scan_phase = dsnp_pkg::PH_INT;
        end else if (c == dsnp_pkg::CH_PLUS) begin
          scan_phase = dsnp_pkg::PH_INT;
        end else if (dig) begin
          add_sig_digit(c);
          scan_phase = dsnp_pkg::PH_INT;
        end else if (c == dsnp_pkg::CH_POINT) begin
          scan_phase = dsnp_pkg::PH_FRAC;
        end else if (expch) begin
          scan_phase = dsnp_pkg::PH_ESIGN;
        end else begin
          scan_phase = dsnp_pkg::PH_DONE;
        end
      end
      dsnp_pkg::PH_INT: begin
        if (dig) add_sig_digit(c);
        else if (c == dsnp_pkg::CH_POINT) scan_phase = dsnp_pkg::PH_FRAC;
        else if (expch) scan_phase = dsnp_pkg::PH_ESIGN;
        else scan_phase = dsnp_pkg::PH_DONE;
      end
      dsnp_pkg::PH_FRAC: begin
        if (dig) begin
          add_sig_digit(c);
          if (scan_frac == dsnp_pkg::FRAC_MAX) scan_clip = 1'b1;
          else scan_frac = scan_frac + 1'b1;
        end else if (expch) begin
          scan_phase = dsnp_pkg::PH_ESIGN;
        end else begin
          scan_phase = dsnp_pkg::PH_DONE;
        end
      end
      dsnp_pkg::PH_ESIGN: begin
        if (c == dsnp_pkg::CH_MINUS) begin
          scan_exp_minus = 1'b1;
          scan_phase     = dsnp_pkg::PH_EDIG;
        end else if (c == dsnp_pkg::CH_PLUS) begin
          scan_phase = dsnp_pkg::PH_EDIG;
        end else if (dig) begin
          add_exp_digit(c);
          scan_phase = dsnp_pkg::PH_EDIG;
        end else begin
          scan_phase = dsnp_pkg::PH_DONE;
        end
      end
      dsnp_pkg::PH_EDIG: begin
        if (dig) add_exp_digit(c);
        else scan_phase = dsnp_pkg::PH_DONE;
      end
      default: scan_phase = dsnp_pkg::PH_DONE;
    endcase
  endtask

  task automatic take_char(input logic [7:0] c, input logic last);
    dsnp_pkg::result_t r;
    if (scan_chars < LINE_LIMIT - 1) begin
      scan_chars++;
      scan_char(c);
    end
    if (last) begin
      r.is_negative       = scan_minus;
      r.significand       = scan_sig;
      r.fraction_digits   = scan_frac;
      r.exponent_negative = scan_exp_minus;
      r.exponent_value    = scan_exp;
      r.saturated         = scan_clip;
      expected_numbers.push_back(r);
      clear_scan();
    end
  endtask

  task automatic add_char(input logic [7:0] c);
    line_buf.push_back(c);
  endtask

  task automatic add_digits(input int n);
    for (int i = 0; i < n; i++) add_char(8'(dsnp_pkg::CH_ZERO + $urandom_range(9)));
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_char(s[i]);
  endtask

  task automatic commit_line();
    dsnp_pkg::char_word_t w;
    if (line_buf.size() == 0) add_char(8'($urandom_range(255)));
    for (int i = 0; i < line_buf.size(); i++) begin
      w.ch       = line_buf[i];
      w.line_end = (i == line_buf.size() - 1);
      char_feed.push_back(w);
    end
    fed_chars += line_buf.size();
    line_count++;
    line_buf.delete();
  endtask

  task automatic make_number();
    int r;
    repeat ($urandom_range(3)) begin
      if ($urandom_range(5) == 0) add_char(dsnp_pkg::CH_SPACE);
      else add_char(8'(dsnp_pkg::CH_TAB + $urandom_range(4)));
    end
    r = $urandom_range(2);
    if (r == 1) add_char(dsnp_pkg::CH_MINUS);
    else if (r == 2) add_char(dsnp_pkg::CH_PLUS);
    add_digits(($urandom_range(9) == 0) ? $urandom_range(24, 18) : $urandom_range(5));
    if ($urandom_range(1) == 1) begin
      add_char(dsnp_pkg::CH_POINT);
      add_digits(($urandom_range(9) == 0) ? $urandom_range(22, 15) : $urandom_range(6));
    end
    if ($urandom_range(2) != 0) begin
      add_char(($urandom_range(1) == 1) ? dsnp_pkg::CH_UP_E : dsnp_pkg::CH_LO_E);
      r = $urandom_range(2);
      if (r == 1) add_char(dsnp_pkg::CH_MINUS);
      else if (r == 2) add_char(dsnp_pkg::CH_PLUS);
      add_digits(($urandom_range(7) == 0) ? $urandom_range(7, 5) : $urandom_range(3));
    end
    repeat ($urandom_range(2)) add_char(8'($urandom_range(255)));
  endtask

  // drive character words
  always @(posedge clk) begin : drive_chars
    dsnp_pkg::char_word_t w;
    if (rst) begin
      char_bus.valid    <= 1'b0;
      char_bus.ch       <= '0;
      char_bus.line_end <= 1'b0;
    end else if (!char_bus.valid || char_bus.ready) begin
      if (char_feed.size() != 0 && (calm_window() || $urandom_range(99) >= 31)) begin
        w = char_feed.pop_front();
        char_bus.valid    <= 1'b1;
        char_bus.ch       <= w.ch;
        char_bus.line_end <= w.line_end;
        sent_count++;
      end else begin
        char_bus.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) num_bus.ready <= 1'b0;
    else num_bus.ready <= calm_window() || $urandom_range(99) >= 31;
  end

  always @(posedge clk) begin
    if (rst) clear_scan();
    else if (char_bus.valid && char_bus.ready) take_char(char_bus.ch, char_bus.line_end);
  end

  always @(posedge clk) begin
    if (rst) quiet_cycles <= 0;
    else if ((char_bus.valid && char_bus.ready) || (num_bus.valid && num_bus.ready))
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  // check parsed numbers
  always @(posedge clk) begin : check_numbers
    dsnp_pkg::result_t exp_r;
    if (!rst && num_bus.valid && num_bus.ready) begin
      if (expected_numbers.size() == 0) begin
        $error("unexpected number word: significand %0d", num_bus.significand);
        fail_count++;
      end else begin
        exp_r = expected_numbers.pop_front();
        numbers_checked++;
        if (exp_r.saturated) clipped_numbers++;
        if (num_bus.is_negative !== exp_r.is_negative) begin
          $error("is_negative: expected %0d, got %0d", exp_r.is_negative, num_bus.is_negative);
          fail_count++;
        end
        if (num_bus.significand !== exp_r.significand) begin
          $error("significand: expected %0d, got %0d", exp_r.significand, num_bus.significand);
          fail_count++;
        end
        if (num_bus.fraction_digits !== exp_r.fraction_digits) begin
          $error("fraction_digits: expected %0d, got %0d", exp_r.fraction_digits,
                 num_bus.fraction_digits);
          fail_count++;
        end
        if (num_bus.exponent_negative !== exp_r.exponent_negative) begin
          $error("exponent_negative: expected %0d, got %0d", exp_r.exponent_negative,
                 num_bus.exponent_negative);
          fail_count++;
        end
        if (num_bus.exponent_value !== exp_r.exponent_value) begin
          $error("exponent_value: expected %0d, got %0d", exp_r.exponent_value,
                 num_bus.exponent_value);
          fail_count++;
        end
        if (num_bus.saturated !== exp_r.saturated) begin
          $error("saturated: expected %0d, got %0d", exp_r.saturated, num_bus.saturated);
          fail_count++;
        end
      end
    end
  end

  initial begin : run_lines
    int pick;
    int missing;
    rst        = 1'b1;
    fed_chars  = 0;
    line_count = 0;
    missing    = 0;

    add_text("\t-12.5E+07");
    commit_line();
    add_text("+.e9");
    commit_line();
    add_text("e5");
    commit_line();
    add_text("7-");
    commit_line();
    add_char(dsnp_pkg::CH_MINUS);
    commit_line();
    add_char(8'hFF);
    commit_line();
    add_char(8'h00);
    commit_line();
    add_text("\r1e-");
    commit_line();

    while (fed_chars < TARGET_CHARS) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        make_number();
      end else if (pick < 85) begin
        make_number();
        if (line_buf.size() != 0)
          line_buf[$urandom_range(line_buf.size() - 1)] = 8'($urandom_range(255));
      end else begin
        repeat ($urandom_range(8, 1)) add_char(8'($urandom_range(255)));
      end
      commit_line();
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while ((char_feed.size() != 0 || char_bus.valid || expected_numbers.size() != 0) &&
           quiet_cycles < QUIET_LIMIT)
      @(negedge clk);

    if (quiet_cycles >= QUIET_LIMIT) begin
      $error("no handshake for %0d cycles, %0d numbers still due", QUIET_LIMIT,
             expected_numbers.size());
      $display("Some tests failed");
    end else begin
      repeat (10) @(negedge clk);
      missing = expected_numbers.size();
      if (missing != 0) $error("%0d numbers never arrived", missing);
      $display("Covered %0d characters in %0d lines: clean numbers, corrupted ones and noise.",
               sent_count, line_count);
      $display("Checked %0d parsed numbers, %0d of them saturated.", numbers_checked,
               clipped_numbers);
      if (fail_count == 0 && missing == 0) $display("All tests passed");
      else $display("Some tests failed");
    end
    $finish;
  end
endmodule

// File: decimal_scientific_number_parser_unit.f
hw/rtl/dsnp_pkg.sv
hw/rtl/dsnp_char_if.sv
hw/rtl/dsnp_num_if.sv
hw/rtl/dsnp_in_reg.sv
hw/rtl/dsnp_parse_core.sv
hw/rtl/dsnp_out_reg.sv
hw/rtl/decimal_scientific_number_parser_unit.sv
tb/tb_top.sv
